@@ src/vfsa_pkg.sv @@
// Package for the four-lane single-precision SIMD ALU.
// Holds payload types, operation codes and the binary32 datapath helpers.
// No dependencies.
package vfsa_pkg;

    localparam logic [2:0] FUNC_ADD   = 3'd0;
    localparam logic [2:0] FUNC_SUB   = 3'd1;
    localparam logic [2:0] FUNC_MUL   = 3'd2;
    localparam logic [2:0] FUNC_SCALE = 3'd3;
    localparam logic [2:0] FUNC_DOT   = 3'd4;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] a_lane0;
        logic [31:0] a_lane1;
        logic [31:0] a_lane2;
        logic [31:0] a_lane3;
        logic [31:0] b_lane0;
        logic [31:0] b_lane1;
        logic [31:0] b_lane2;
        logic [31:0] b_lane3;
        logic [31:0] scale_factor;
    } req_t;

    typedef struct packed {
        logic [31:0] r_lane0;
        logic [31:0] r_lane1;
        logic [31:0] r_lane2;
        logic [31:0] r_lane3;
        logic [31:0] dot_sum;
    } rsp_t;

    // Wide unrounded value: either a finished special result or sign*sig*2^exp
    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [11:0] exp;
        logic [63:0]        sig;
    } fp_wide_t;

    function automatic logic is_nan(input logic [31:0] x);
        return x[30:0] > INF_MAG;
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return x[30:0] == INF_MAG;
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] unp_sig(input logic [31:0] x);
        return {(x[30:23] != 8'd0), x[22:0]};
    endfunction

    function automatic logic signed [11:0] unp_exp(input logic [31:0] x);
        logic signed [11:0] e;
        if (x[30:23] == 8'd0)
            e = -12'sd149;
        else
            e = $signed({4'b0, x[30:23]}) - 12'sd150;
        return e;
    endfunction

    function automatic logic [49:0] shr_jam50(input logic [49:0] x, input logic [11:0] n);
        logic [49:0] mask;
        logic [49:0] r;
        if (n >= 12'd50) begin
            r = {49'd0, (x != 50'd0)};
        end
        else begin
            mask = (50'd1 << n[5:0]) - 50'd1;
            r = (x >> n[5:0]) | {49'd0, ((x & mask) != 50'd0)};
        end
        return r;
    endfunction

    function automatic logic [63:0] shr_jam64(input logic [63:0] x, input logic [11:0] n);
        logic [63:0] mask;
        logic [63:0] r;
        if (n >= 12'd64) begin
            r = {63'd0, (x != 64'd0)};
        end
        else begin
            mask = (64'd1 << n[5:0]) - 64'd1;
            r = (x >> n[5:0]) | {63'd0, ((x & mask) != 64'd0)};
        end
        return r;
    endfunction

    // Multiply front end: specials and the exact 48-bit significand product
    function automatic fp_wide_t mul_front(input logic [31:0] a, input logic [31:0] b);
        fp_wide_t r;
        r = '0;
        r.sign = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) begin
            r.spec = 1'b1;
            r.spec_val = QNAN_BITS;
        end
        else if (is_inf(a) || is_inf(b)) begin
            r.spec = 1'b1;
            if (is_zero(a) || is_zero(b))
                r.spec_val = QNAN_BITS;
            else
                r.spec_val = {a[31] ^ b[31], INF_MAG};
        end
        else if (is_zero(a) || is_zero(b)) begin
            r.spec = 1'b1;
            r.spec_val = {a[31] ^ b[31], 31'd0};
        end
        else begin
            r.sig = {16'd0, 48'(unp_sig(a)) * 48'(unp_sig(b))};
            r.exp = unp_exp(a) + unp_exp(b);
        end
        return r;
    endfunction

    // Add front end: specials, alignment with sticky, and the exact sum
    function automatic fp_wide_t add_front(input logic [31:0] a, input logic [31:0] b);
        fp_wide_t           r;
        logic [49:0]        ma;
        logic [49:0]        mb;
        logic [50:0]        m;
        logic signed [11:0] ea;
        logic signed [11:0] eb;
        logic signed [11:0] d;
        logic signed [11:0] e;
        r = '0;
        ma = {unp_sig(a), 26'd0};
        mb = {unp_sig(b), 26'd0};
        ea = unp_exp(a);
        eb = unp_exp(b);
        d = ea - eb;
        m = '0;
        e = ea;
        if (is_nan(a) || is_nan(b)) begin
            r.spec = 1'b1;
            r.spec_val = QNAN_BITS;
        end
        else if (is_inf(a) && is_inf(b)) begin
            r.spec = 1'b1;
            r.spec_val = (a[31] == b[31]) ? a : QNAN_BITS;
        end
        else if (is_inf(a)) begin
            r.spec = 1'b1;
            r.spec_val = a;
        end
        else if (is_inf(b)) begin
            r.spec = 1'b1;
            r.spec_val = b;
        end
        else if (is_zero(a) && is_zero(b)) begin
            r.spec = 1'b1;
            r.spec_val = {a[31] & b[31], 31'd0};
        end
        else if (is_zero(a)) begin
            r.spec = 1'b1;
            r.spec_val = b;
        end
        else if (is_zero(b)) begin
            r.spec = 1'b1;
            r.spec_val = a;
        end
        else begin
            if (d >= 12'sd0) begin
                mb = shr_jam50(mb, d);
                e = ea;
            end
            else begin
                ma = shr_jam50(ma, -d);
                e = eb;
            end
            if (a[31] == b[31]) begin
                m = {1'b0, ma} + {1'b0, mb};
                r.sign = a[31];
            end
            else if (ma >= mb) begin
                m = {1'b0, ma} - {1'b0, mb};
                r.sign = a[31];
            end
            else begin
                m = {1'b0, mb} - {1'b0, ma};
                r.sign = b[31];
            end
            if (m == 51'd0) begin
                r.spec = 1'b1;
                r.spec_val = 32'd0;
            end
            r.sig = {13'd0, m};
            r.exp = e - 12'sd26;
        end
        return r;
    endfunction

    // Bring the leading one to bit 63
    function automatic fp_wide_t norm(input fp_wide_t x);
        fp_wide_t   r;
        logic [6:0] lz;
        r = x;
        lz = '0;
        for (int i = 0; i < 64; i++) begin
            if (x.sig[i])
                lz = 7'(63 - i);
        end
        if (!x.spec) begin
            r.sig = x.sig << lz[5:0];
            r.exp = x.exp - $signed({5'd0, lz});
        end
        return r;
    endfunction

    // Round a normalized value to nearest even, with gradual underflow
    function automatic logic [31:0] round_pack(input fp_wide_t x);
        logic signed [11:0] e;
        logic [63:0]        sig;
        logic [24:0]        mant;
        logic [39:0]        rem;
        logic [31:0]        bits;
        logic [31:0]        r;
        e = x.exp + 12'sd190;
        sig = x.sig;
        if (x.spec) begin
            r = x.spec_val;
        end
        else if (e >= 12'sd255) begin
            r = {x.sign, INF_MAG};
        end
        else begin
            if (e <= 12'sd0) begin
                sig = shr_jam64(sig, 12'sd1 - e);
                e = 12'sd1;
            end
            mant = {1'b0, sig[63:40]};
            rem = sig[39:0];
            if (rem > 40'h80_0000_0000 || (rem == 40'h80_0000_0000 && mant[0]))
                mant = mant + 25'd1;
            bits = ((32'(e) - 32'd1) << 23) + 32'(mant);
            if (bits >= {1'b0, INF_MAG})
                bits = {1'b0, INF_MAG};
            r = {x.sign, bits[30:0]};
        end
        return r;
    endfunction

endpackage

@@ src/vfsa_stream_if.sv @@
// Valid/ready stream interface carrying one request or response payload.
// Depends on nothing; the payload type is given at instantiation.
interface vfsa_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/vfsa_fmul.sv @@
// Three-stage binary32 multiplier: product, normalize, round.
// Depends on vfsa_pkg.
module vfsa_fmul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);
    import vfsa_pkg::*;

    fp_wide_t    prod_reg;
    fp_wide_t    norm_reg;
    logic [31:0] p_reg;

    // Advance the three stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= mul_front(a, b);
            norm_reg <= norm(prod_reg);
            p_reg    <= round_pack(norm_reg);
        end
    end

    assign p = p_reg;
endmodule

@@ src/vfsa_fadd.sv @@
// Three-stage binary32 adder: align and add, normalize, round.
// Depends on vfsa_pkg.
module vfsa_fadd (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] s
);
    import vfsa_pkg::*;

    fp_wide_t    sum_reg;
    fp_wide_t    norm_reg;
    logic [31:0] s_reg;

    // Advance the three stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= add_front(a, b);
            norm_reg <= norm(sum_reg);
            s_reg    <= round_pack(norm_reg);
        end
    end

    assign s = s_reg;
endmodule

@@ src/vec4_float_simd_alu.sv @@
// Top level of the four-lane single-precision SIMD ALU with dot product.
// Depends on vfsa_pkg, vfsa_stream_if, vfsa_fmul and vfsa_fadd.
//
//   port      dir   payload  contents
//   in_req    sink  req_t    func, a_lane0..3, b_lane0..3, scale_factor
//   out_rsp   src   rsp_t    r_lane0..3, dot_sum
//
// The pipe is built from 3 multiplier stages, 3 stages of the first adder row
// and 3 stages of the dot adder. One request enters per cycle while the output is not stalled.
// Reset clears only the valid bits of the nine stages.
// A stalled output freezes the whole pipeline; in_req.ready drops with it.
module vec4_float_simd_alu (
    input  logic          clk,
    input  logic          rst_n,
    vfsa_stream_if.sink   in_req,
    vfsa_stream_if.source out_rsp
);
    import vfsa_pkg::*;

    localparam int DEPTH = 9;

    logic              en;
    logic [DEPTH-1:0]  v_reg;
    logic [2:0]        func_reg [DEPTH];
    logic [31:0]       a_reg    [3][4];
    logic [31:0]       b_reg    [3][4];
    logic [31:0]       mres_reg [6][4];
    logic [31:0]       ares_reg [3][4];
    logic [31:0]       a_in [4];
    logic [31:0]       b_in [4];
    logic [31:0]       mul_b [4];
    logic [31:0]       prod [4];
    logic [31:0]       add_a [4];
    logic [31:0]       add_b [4];
    logic [31:0]       sum1 [4];
    logic [31:0]       dot;
    logic              is_dot3;
    logic [2:0]        f_out;

    assign en = !v_reg[DEPTH-1] || out_rsp.ready;
    assign in_req.ready = en;

    assign a_in[0] = in_req.data.a_lane0;
    assign a_in[1] = in_req.data.a_lane1;
    assign a_in[2] = in_req.data.a_lane2;
    assign a_in[3] = in_req.data.a_lane3;
    assign b_in[0] = in_req.data.b_lane0;
    assign b_in[1] = in_req.data.b_lane1;
    assign b_in[2] = in_req.data.b_lane2;
    assign b_in[3] = in_req.data.b_lane3;

    // Track valid bits along the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DEPTH-2:0], in_req.valid};
    end

    // Carry operation codes and operands alongside the datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func_reg[0] <= in_req.data.func;
            for (int i = 1; i < DEPTH; i++)
                func_reg[i] <= func_reg[i-1];
            for (int l = 0; l < 4; l++)
            begin
                a_reg[0][l] <= a_in[l];
                b_reg[0][l] <= b_in[l];
                for (int i = 1; i < 3; i++)
                begin
                    a_reg[i][l] <= a_reg[i-1][l];
                    b_reg[i][l] <= b_reg[i-1][l];
                end
                mres_reg[0][l] <= prod[l];
                for (int i = 1; i < 6; i++)
                    mres_reg[i][l] <= mres_reg[i-1][l];
                ares_reg[0][l] <= sum1[l];
                for (int i = 1; i < 3; i++)
                    ares_reg[i][l] <= ares_reg[i-1][l];
            end
        end
    end

    // Multiplier row: scale uses the scalar as second operand
    for (genvar l = 0; l < 4; l++)
    begin : g_mul
        assign mul_b[l] = (in_req.data.func == FUNC_SCALE) ? in_req.data.scale_factor
                                                           : b_in[l];
        vfsa_fmul u_mul (
            .clk (clk),
            .en  (en),
            .a   (a_in[l]),
            .b   (mul_b[l]),
            .p   (prod[l])
        );
    end

    // First adder row: lanewise add/sub, or the two pair sums of a dot
    assign is_dot3 = (func_reg[2] == FUNC_DOT);
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            add_a[l] = a_reg[2][l];
            add_b[l] = (func_reg[2] == FUNC_SUB) ? {~b_reg[2][l][31], b_reg[2][l][30:0]}
                                                 : b_reg[2][l];
        end
        if (is_dot3)
        begin
            add_a[0] = prod[0];
            add_b[0] = prod[1];
            add_a[1] = prod[2];
            add_b[1] = prod[3];
        end
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_add
        vfsa_fadd u_add (
            .clk (clk),
            .en  (en),
            .a   (add_a[l]),
            .b   (add_b[l]),
            .s   (sum1[l])
        );
    end

    // Final dot adder
    vfsa_fadd u_dot (
        .clk (clk),
        .en  (en),
        .a   (sum1[0]),
        .b   (sum1[1]),
        .s   (dot)
    );

    // Select the response fields by operation
    assign f_out = func_reg[DEPTH-1];
    always_comb
    begin
        out_rsp.data = '0;
        case (f_out) inside
            FUNC_ADD, FUNC_SUB:
            begin
                out_rsp.data.r_lane0 = ares_reg[2][0];
                out_rsp.data.r_lane1 = ares_reg[2][1];
                out_rsp.data.r_lane2 = ares_reg[2][2];
                out_rsp.data.r_lane3 = ares_reg[2][3];
            end
            FUNC_MUL, FUNC_SCALE:
            begin
                out_rsp.data.r_lane0 = mres_reg[5][0];
                out_rsp.data.r_lane1 = mres_reg[5][1];
                out_rsp.data.r_lane2 = mres_reg[5][2];
                out_rsp.data.r_lane3 = mres_reg[5][3];
            end
            FUNC_DOT:
                out_rsp.data.dot_sum = dot;
            default:
                out_rsp.data = '0;
        endcase
    end

    assign out_rsp.valid = v_reg[DEPTH-1];

    // Pipeline holds while the output is stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved during stall");

    // Dot responses carry zero in lanes 0 and 3
    a_dot_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        out_rsp.valid && f_out == FUNC_DOT |->
        (out_rsp.data.r_lane0 == 32'd0 && out_rsp.data.r_lane3 == 32'd0))
        else $error("dot response with nonzero lanes");

    // Lanewise responses carry a zero dot sum
    a_lane_dot: assert property (@(posedge clk) disable iff (!rst_n)
        out_rsp.valid && f_out != FUNC_DOT |-> out_rsp.data.dot_sum == 32'd0)
        else $error("lanewise response with nonzero dot sum");

    // Any NaN on the dot sum is the canonical quiet NaN
    a_qnan: assert property (@(posedge clk) disable iff (!rst_n)
        out_rsp.valid && out_rsp.data.dot_sum[30:0] > INF_MAG |->
        out_rsp.data.dot_sum == QNAN_BITS)
        else $error("non-canonical NaN on dot sum");
endmodule
